### hw/rtl/deq_pkg.sv
// Package for the double-ended queue: request and response types, action and
// status codes, and default sizes. No dependencies.
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int WORD_WIDTH_DEF = 64;
    localparam int PUSH_W         = 64;
    localparam int OCC_W          = 11;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_PEEK_FRONT = 3'd4,
        ACT_PEEK_BACK  = 3'd5,
        ACT_CLEAR      = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_WORD  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        t_action           action;
        logic [PUSH_W-1:0] push_word;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [PUSH_W-1:0] read_word;
        logic [OCC_W-1:0]  occupancy;
    } t_rsp;

    // Registered result information from the controller to the top level.
    typedef struct packed {
        logic             done;
        logic             rd;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_rsp_ctl;

endpackage

`default_nettype wire

### hw/rtl/double_ended_queue_top.sv
// Top level of the double-ended queue: controller plus word store.
// Depends on deq_pkg, deq_ctrl and deq_mem.
//
//   channel    ports                 handshake
//   request    i_req (t_req)         accepted at a rising edge with start high, busy low
//   response   o_rsp (t_rsp)         valid for one cycle while o_done is high
//
// Every request gives one response, on the cycle right after its accept edge.
// A new request can be accepted every cycle: pointer and count update at the
// accept edge, and the store access of a request, if any (a write for a push
// with room, a read for a pop or peek of a nonempty queue), completes at that
// same edge, the read data being registered in the store's read port and
// shown in the response cycle, which is why the response follows that edge.
// Reset is synchronous and active low; busy is high during reset and until
// the live register is set after it, then stays low. The store needs no
// clearing pass: only entries inside the occupied span are ever read.
// The receiver cannot stall, so the response is never held.
`default_nettype none

module double_ended_queue_top #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = deq_pkg::WORD_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire deq_pkg::t_req i_req,
    output logic               o_done,
    output deq_pkg::t_rsp      o_rsp
);

    localparam int AW = $clog2(DEPTH);

    logic                        live;
    logic                        accept;
    logic                        we;
    logic                        re;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               raddr;
    logic [WORD_WIDTH-1:0]       wdata;
    logic [WORD_WIDTH-1:0]       rdata;
    deq_pkg::t_rsp_ctl           ctl;
    logic [deq_pkg::PUSH_W+WORD_WIDTH-1:0] rdata_wide;

    assign busy   = !live;
    assign accept = start && !busy;

    deq_ctrl #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .o_live   (live),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_re     (re),
        .o_raddr  (raddr),
        .o_ctl    (ctl)
    );

    deq_mem #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // The read word is zero unless this response returns a word.
    assign rdata_wide = {{deq_pkg::PUSH_W{1'b0}}, rdata};

    always_comb begin
        o_done          = ctl.done;
        o_rsp.status    = ctl.status;
        o_rsp.occupancy = ctl.occupancy;
        o_rsp.read_word = ctl.rd ? rdata_wide[deq_pkg::PUSH_W-1:0] : '0;
    end

endmodule

`default_nettype wire

### hw/rtl/deq_mem.sv
// Word store of the double-ended queue: one write port and one read port with
// registered read data. Depends on nothing but its parameters.
`default_nettype none

module deq_mem #(
    parameter int DEPTH      = 1024,
    parameter int WORD_WIDTH = 64,
    localparam int AW        = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [WORD_WIDTH-1:0] i_wdata,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [WORD_WIDTH-1:0] o_rdata
);

    logic [WORD_WIDTH-1:0] r_mem [DEPTH];
    logic [WORD_WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

### hw/rtl/deq_ctrl.sv
// Head pointer, word count and action decode of the double-ended queue.
// Drives the store's ports and registers the result. Depends on deq_pkg.
`default_nettype none

module deq_ctrl #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = deq_pkg::WORD_WIDTH_DEF,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire deq_pkg::t_req     i_req,
    output logic                   o_live,
    output logic                   o_we,
    output logic [AW-1:0]          o_waddr,
    output logic [WORD_WIDTH-1:0]  o_wdata,
    output logic                   o_re,
    output logic [AW-1:0]          o_raddr,
    output deq_pkg::t_rsp_ctl      o_ctl
);

    logic [AW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_live;
    logic                  r_done;
    logic                  r_rd, n_rd;
    deq_pkg::t_status      r_status, n_status;
    logic [AW-1:0]         front_pos, tail_pos, back_pos, head_inc;
    logic [AW:0]           sum, sum_m1;
    logic                  full, empty;
    logic [CW+deq_pkg::OCC_W-1:0] occ_wide;

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    // Ring positions; every sum stays below twice the depth, so one
    // compare and subtract wraps it.
    assign sum    = (AW+1)'(r_head) + (AW+1)'(r_count);
    assign sum_m1 = sum - (AW+1)'(1);
    assign tail_pos  = (sum >= (AW+1)'(DEPTH)) ? AW'(sum - (AW+1)'(DEPTH)) : AW'(sum);
    assign back_pos  = (sum_m1 >= (AW+1)'(DEPTH)) ? AW'(sum_m1 - (AW+1)'(DEPTH))
                                                  : AW'(sum_m1);
    assign front_pos = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = deq_pkg::ST_OK;
        n_rd     = 1'b0;
        o_we     = 1'b0;
        o_waddr  = tail_pos;
        o_re     = 1'b0;
        o_raddr  = r_head;
        o_wdata  = i_req.push_word[WORD_WIDTH-1:0];
        if (i_accept) begin
            case (i_req.action)
                deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
                    if (full) begin
                        n_status = deq_pkg::ST_FULL;
                    end else begin
                        o_we    = 1'b1;
                        n_count = r_count + CW'(1);
                        if (i_req.action == deq_pkg::ACT_PUSH_FRONT) begin
                            o_waddr = front_pos;
                            n_head  = front_pos;
                        end
                    end
                end
                deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK,
                deq_pkg::ACT_PEEK_FRONT, deq_pkg::ACT_PEEK_BACK: begin
                    if (empty) begin
                        n_status = deq_pkg::ST_EMPTY;
                    end else begin
                        o_re     = 1'b1;
                        n_rd     = 1'b1;
                        n_status = deq_pkg::ST_WORD;
                        if (i_req.action == deq_pkg::ACT_POP_BACK ||
                            i_req.action == deq_pkg::ACT_PEEK_BACK) begin
                            o_raddr = back_pos;
                        end
                        if (i_req.action == deq_pkg::ACT_POP_FRONT) begin
                            n_head  = head_inc;
                            n_count = r_count - CW'(1);
                        end else if (i_req.action == deq_pkg::ACT_POP_BACK) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
                deq_pkg::ACT_CLEAR: begin
                    n_head  = '0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_live  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_live  <= 1'b1;
            r_done  <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd     <= n_rd;
            r_status <= n_status;
        end
    end

    // The occupancy field reports the count after the action; the count
    // register already holds it in the result cycle.
    assign occ_wide = {{deq_pkg::OCC_W{1'b0}}, r_count};

    assign o_live          = r_live;
    assign o_ctl.done      = r_done;
    assign o_ctl.rd        = r_rd;
    assign o_ctl.status    = r_status;
    assign o_ctl.occupancy = occ_wide[deq_pkg::OCC_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/deq_chk.sv
// Port-level checker for the double-ended queue and its bind to the top level.
// Depends on deq_pkg and double_ended_queue_top.
`default_nettype none

module deq_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire deq_pkg::t_req i_req,
    input wire logic          o_done,
    input wire deq_pkg::t_rsp o_rsp
);

    // A response appears only on the cycle after an accepted request.
    a_done_follows_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy))
        else $error("response without a request");

    // Every accepted request gives a response on the next cycle.
    a_req_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("request without a response");

    // Only a returned word carries a nonzero read word.
    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != deq_pkg::ST_WORD) |-> (o_rsp.read_word == '0))
        else $error("read word set without a returned word");

    // An empty error leaves the queue empty.
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == deq_pkg::ST_EMPTY) |-> (o_rsp.occupancy == '0))
        else $error("empty error with words held");

    // A clear reports success and an empty queue.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.action == deq_pkg::ACT_CLEAR)
        |=> (o_rsp.status == deq_pkg::ST_OK && o_rsp.occupancy == '0))
        else $error("clear did not empty the queue");

endmodule

bind double_ended_queue_top deq_chk u_deq_chk (.*);

`default_nettype wire
